[src/sfsg_pkg.sv]
// Shared types and constants of the stick flick swipe generator.
// No dependencies; used by the top level and the checker.
package sfsg_pkg;

    // Width of every payload coordinate and stick field on the ports
    localparam int FIELD_W = 16;

    // Configuration port shape
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 12;

    typedef logic [CFG_AW-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_ENABLE   = 3'd0;
    localparam cfg_idx_t CFG_LENGTH   = 3'd1;
    localparam cfg_idx_t CFG_FRAMES   = 3'd2;
    localparam cfg_idx_t CFG_DEADZONE = 3'd3;
    localparam cfg_idx_t CFG_WIDTH    = 3'd4;
    localparam cfg_idx_t CFG_HEIGHT   = 3'd5;

    // Pointer event kinds
    typedef logic [1:0] kind_t;

    localparam kind_t EV_DOWN = 2'd0;
    localparam kind_t EV_MOVE = 2'd1;
    localparam kind_t EV_UP   = 2'd2;

    // Threshold arithmetic
    localparam logic [31:0] REST_MAX    = 32'd10;
    localparam logic [31:0] K_REARM     = 32'd196602;
    localparam logic [31:0] K_ARM       = 32'd32767;
    localparam logic [31:0] SCALE_REARM = 32'd1000000;
    localparam logic [31:0] SCALE_ARM   = 32'd10000;
    localparam logic [6:0]  PCT_MIN     = 7'd5;
    localparam logic [6:0]  PCT_MAX     = 7'd95;
    localparam logic [7:0]  FRAMES_MIN  = 8'd2;

endpackage

[src/sfsg_div.sv]
// Restoring divider, one quotient bit per cycle.
// Standalone; used by the top level for edge fitting, end points and moves.
module sfsg_div #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);

    localparam int CNW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW-1:0] rem_new;

    // Bring down one dividend bit and try the subtraction
    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NW-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_new = ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
    end

    // Control: load on start, run NW steps, flag completion for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= rem_new;
        end
    end

    assign quo  = num_reg;
    assign done = done_reg;

endmodule

[src/sfsg_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; used by the top level for the stick radius.
module sfsg_sqrt #(
    parameter int N = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N-1:0]   radicand,
    output logic [N/2-1:0] root,
    output logic           done
);

    localparam int RW  = N / 2;
    localparam int CNW = $clog2(RW + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [N-1:0]   rad_reg;
    logic [RW:0]    rem_reg;
    logic [RW-1:0]  root_reg;

    logic [RW+2:0]  rem_sh;
    logic [RW+2:0]  trial;
    logic           ge;

    // Bring down two radicand bits and test root*4+1
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[N-1:N-2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = rem_sh >= trial;
    end

    // Control: RW steps per root
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNW'(RW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[N-3:0], 2'b00};
            rem_reg  <= ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

[src/stick_flick_swipe_generator.sv]
// Top level of the stick flick swipe generator: sequencer, shared multiplier.
// Depends on sfsg_pkg, sfsg_div and sfsg_sqrt.
//
// Usage: one input request per video frame on in_valid/in_ready carries the
// stick sample and the cursor. Each request yields zero or one pointer event
// on out_valid/out_ready. Configuration is written on cfg_we/cfg_addr/
// cfg_wdata while the block is idle.
// Work done per request, with no stall; divides and the root are serial:
//   - no flick check, or no flick: at most the stick squares and threshold checks;
//   - a flick: the threshold checks, the root, an edge fit per axis that can
//     move (a multiply and a divide), the end point per axis (a multiply and
//     a divide) and the down event;
//   - a move frame: a multiply and a divide per axis, then the move event
//     unless it has no delta; an up frame: the up event only.
// One request is worked on at a time; in_ready is high only between
// requests. A finished event waits in the output register, and the next
// request is taken meanwhile; if the receiver still stalls when the next
// event is ready, the sequencer holds until the register frees up.
// Reset clears the stroke state and loads the register defaults; no
// clearing pass is needed.
module stick_flick_swipe_generator #(
    parameter int FRAC_BITS  = 4,
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sfsg_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [sfsg_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [sfsg_pkg::FIELD_W-1:0] stick_x,
    input  logic signed [sfsg_pkg::FIELD_W-1:0] stick_y,
    input  logic [sfsg_pkg::FIELD_W-1:0]  cursor_x,
    input  logic [sfsg_pkg::FIELD_W-1:0]  cursor_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    event_kind,
    output logic [sfsg_pkg::FIELD_W-1:0]  prev_x,
    output logic [sfsg_pkg::FIELD_W-1:0]  prev_y,
    output logic [sfsg_pkg::FIELD_W-1:0]  pos_x,
    output logic [sfsg_pkg::FIELD_W-1:0]  pos_y
);

    localparam int FW  = sfsg_pkg::FIELD_W;
    localparam int PTW = (COORD_BITS > FW) ? COORD_BITS : FW;
    localparam int LW  = 12 + FRAC_BITS;
    localparam int NW  = 48;
    localparam int DW  = 32;
    localparam int SQN = 48;
    localparam int SQR = SQN / 2;

    localparam logic signed [31:0] MARGIN = 32'(2 << FRAC_BITS);
    localparam logic [LW-1:0]      MINLEN = LW'(8 << FRAC_BITS);
    localparam logic [PTW-1:0]     CMAX   = PTW'({COORD_BITS{1'b1}});

    // Sequencer states
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQX  = 5'd1;
    localparam logic [4:0] S_SQY  = 5'd2;
    localparam logic [4:0] S_CHK0 = 5'd3;
    localparam logic [4:0] S_M1   = 5'd4;
    localparam logic [4:0] S_M2   = 5'd5;
    localparam logic [4:0] S_M3   = 5'd6;
    localparam logic [4:0] S_CMP1 = 5'd7;
    localparam logic [4:0] S_M4   = 5'd8;
    localparam logic [4:0] S_M5   = 5'd9;
    localparam logic [4:0] S_M6   = 5'd10;
    localparam logic [4:0] S_CMP2 = 5'd11;
    localparam logic [4:0] S_SQRT = 5'd12;
    localparam logic [4:0] S_AXIS = 5'd13;
    localparam logic [4:0] S_AMUL = 5'd14;
    localparam logic [4:0] S_ADST = 5'd15;
    localparam logic [4:0] S_ADW  = 5'd16;
    localparam logic [4:0] S_LCHK = 5'd17;
    localparam logic [4:0] S_EMUL = 5'd18;
    localparam logic [4:0] S_EDST = 5'd19;
    localparam logic [4:0] S_EDW  = 5'd20;
    localparam logic [4:0] S_ADV  = 5'd21;
    localparam logic [4:0] S_VMUL = 5'd22;
    localparam logic [4:0] S_VDST = 5'd23;
    localparam logic [4:0] S_VDW  = 5'd24;
    localparam logic [4:0] S_VFIN = 5'd25;
    localparam logic [4:0] S_EMIT = 5'd26;

    // Configuration registers
    logic        en_reg;
    logic [11:0] len_cfg_reg;
    logic [7:0]  frames_reg;
    logic [6:0]  pct_reg;
    logic [11:0] sw_reg;
    logic [11:0] sh_reg;

    // Request and stroke state
    logic [4:0]            state_reg;
    logic signed [FW-1:0]  sx_reg, sy_reg;
    logic [FW-1:0]         cx_reg, cy_reg;
    logic                  armed_reg, active_reg;
    logic [7:0]            fidx_reg, ftot_reg;
    logic [PTW-1:0]        start_x_reg, start_y_reg;
    logic [PTW-1:0]        end_x_reg, end_y_reg;
    logic [PTW-1:0]        last_x_reg, last_y_reg;
    logic [PTW-1:0]        new_x_reg, new_y_reg;
    logic [31:0]           s2_reg;
    logic [63:0]           t1_reg, t2_reg;
    logic [SQR-1:0]        r_reg;
    logic [LW-1:0]         len_reg;
    logic                  sel_reg;

    // Pending and output event
    sfsg_pkg::kind_t       pk_reg;
    logic [PTW-1:0]        pprev_x_reg, pprev_y_reg, ppos_x_reg, ppos_y_reg;
    logic                  ov_reg;
    sfsg_pkg::kind_t       ok_reg;
    logic [FW-1:0]         oprev_x_reg, oprev_y_reg, opos_x_reg, opos_y_reg;

    // Datapath signals
    logic signed [FW:0]    sx_e, sy_e, dsy_e, s_cur;
    logic [FW:0]           ax, ay, a_cur;
    logic [FW-1:0]         c_cur;
    logic [31:0]           size_q;
    logic signed [31:0]    room;
    logic [6:0]            pct;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           mul_p;
    logic signed [PTW:0]   dx, dy, d_cur;
    logic [PTW:0]          ad_cur;
    logic [PTW-1:0]        st_cur;
    logic                  div_start;
    logic [NW-1:0]         div_num, div_quo;
    logic [DW-1:0]         div_den;
    logic                  div_done;
    logic                  sq_start, sq_done;
    logic [SQR-1:0]        sq_root;
    logic                  arm_skip;
    logic [PTW-1:0]        end_new, mov_new;

    // Saturating base plus or minus a magnitude
    function automatic logic [PTW-1:0] sat_add(input logic [PTW-1:0] base,
                                               input logic [NW-1:0] q,
                                               input logic neg);
        logic signed [NW+1:0] v;
        logic signed [NW+1:0] qs;
        qs = $signed({2'b00, q});
        v  = $signed((NW+2)'(base)) + (neg ? -qs : qs);
        if (v < 0)
            sat_add = '0;
        else if (v > $signed((NW+2)'(CMAX)))
            sat_add = CMAX;
        else
            sat_add = v[PTW-1:0];
    endfunction

    // Stick magnitudes and the axis under work
    always_comb
    begin
        sx_e   = (FW+1)'(sx_reg);
        sy_e   = (FW+1)'(sy_reg);
        dsy_e  = (FW+1)'(-sy_e);
        ax     = sx_e[FW] ? (FW+1)'(-sx_e) : (FW+1)'(sx_e);
        ay     = sy_e[FW] ? (FW+1)'(-sy_e) : (FW+1)'(sy_e);
        s_cur  = sel_reg ? dsy_e : sx_e;
        a_cur  = sel_reg ? ay : ax;
        c_cur  = sel_reg ? cy_reg : cx_reg;
        size_q = 32'(sel_reg ? sh_reg : sw_reg) << FRAC_BITS;
        if (s_cur > 0)
            room = $signed(size_q) - MARGIN - $signed(32'(c_cur));
        else
            room = $signed(32'(c_cur)) - MARGIN;
        if (pct_reg < sfsg_pkg::PCT_MIN)
            pct = sfsg_pkg::PCT_MIN;
        else if (pct_reg > sfsg_pkg::PCT_MAX)
            pct = sfsg_pkg::PCT_MAX;
        else
            pct = pct_reg;
        dx     = $signed({1'b0, end_x_reg}) - $signed({1'b0, start_x_reg});
        dy     = $signed({1'b0, end_y_reg}) - $signed({1'b0, start_y_reg});
        d_cur  = sel_reg ? dy : dx;
        ad_cur = d_cur[PTW] ? (PTW+1)'(-d_cur) : (PTW+1)'(d_cur);
        st_cur = sel_reg ? start_y_reg : start_x_reg;
        arm_skip = (t1_reg < t2_reg) || armed_reg;
        end_new = sat_add(PTW'(c_cur), div_quo, s_cur[FW]);
        mov_new = sat_add(st_cur, div_quo, d_cur[PTW]);
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:
            begin
                mul_a = 32'(ax);
                mul_b = 32'(ax);
            end
            S_SQY:
            begin
                mul_a = 32'(ay);
                mul_b = 32'(ay);
            end
            S_M1:
            begin
                mul_a = s2_reg;
                mul_b = sfsg_pkg::SCALE_REARM;
            end
            S_M2:
            begin
                mul_a = sfsg_pkg::K_REARM;
                mul_b = 32'(pct);
            end
            S_M4:
            begin
                mul_a = s2_reg;
                mul_b = sfsg_pkg::SCALE_ARM;
            end
            S_M5:
            begin
                mul_a = sfsg_pkg::K_ARM;
                mul_b = 32'(pct);
            end
            S_M3, S_M6:
            begin
                mul_a = t2_reg[31:0];
                mul_b = t2_reg[31:0];
            end
            S_AMUL:
            begin
                mul_a = room;
                mul_b = 32'(r_reg);
            end
            S_EMUL:
            begin
                mul_a = 32'(a_cur);
                mul_b = 32'(len_reg);
            end
            S_VMUL:
            begin
                mul_a = 32'(ad_cur);
                mul_b = 32'(fidx_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    // Divider operand select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_ADST:
            begin
                div_start = 1'b1;
                div_num   = t1_reg[NW-1:0];
                div_den   = DW'(a_cur) << 8;
            end
            S_EDST:
            begin
                div_start = 1'b1;
                div_num   = {t1_reg[NW-9:0], 8'h00} + NW'(r_reg >> 1);
                div_den   = DW'(r_reg);
            end
            S_VDST:
            begin
                div_start = 1'b1;
                div_num   = t1_reg[NW-1:0] + NW'(ftot_reg >> 1);
                div_den   = DW'(ftot_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sq_start = (state_reg == S_CMP2) && !arm_skip;

    sfsg_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    sfsg_sqrt #(.N(SQN)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand ({s2_reg, 16'h0000}),
        .root     (sq_root),
        .done     (sq_done)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg      <= 1'b1;
            len_cfg_reg <= 12'd400;
            frames_reg  <= 8'd8;
            pct_reg     <= 7'd50;
            sw_reg      <= 12'd1920;
            sh_reg      <= 12'd1080;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                sfsg_pkg::CFG_ENABLE:   en_reg      <= cfg_wdata[0];
                sfsg_pkg::CFG_LENGTH:   len_cfg_reg <= cfg_wdata;
                sfsg_pkg::CFG_FRAMES:   frames_reg  <= cfg_wdata[7:0];
                sfsg_pkg::CFG_DEADZONE: pct_reg     <= cfg_wdata[6:0];
                sfsg_pkg::CFG_WIDTH:    sw_reg      <= cfg_wdata;
                sfsg_pkg::CFG_HEIGHT:   sh_reg      <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    // Sequencer and stroke state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            armed_reg   <= 1'b0;
            active_reg  <= 1'b0;
            fidx_reg    <= '0;
            ftot_reg    <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
            sel_reg     <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            // Drop the output event once taken, unless a new one replaces it
            if (ov_reg && out_ready && state_reg != S_EMIT)
                ov_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        sx_reg    <= stick_x;
                        sy_reg    <= stick_y;
                        cx_reg    <= cursor_x;
                        cy_reg    <= cursor_y;
                        state_reg <= (en_reg && !active_reg) ? S_SQX : S_ADV;
                    end
                end
                S_SQX:
                begin
                    s2_reg    <= mul_p[31:0];
                    state_reg <= S_SQY;
                end
                S_SQY:
                begin
                    s2_reg    <= s2_reg + mul_p[31:0];
                    state_reg <= S_CHK0;
                end
                S_CHK0:
                begin
                    if (s2_reg <= sfsg_pkg::REST_MAX)
                    begin
                        armed_reg <= 1'b0;
                        state_reg <= S_ADV;
                    end
                    else
                        state_reg <= S_M1;
                end
                S_M1:
                begin
                    t1_reg    <= mul_p;
                    state_reg <= S_M2;
                end
                S_M2, S_M3:
                begin
                    t2_reg    <= mul_p;
                    state_reg <= state_reg + 1'b1;
                end
                S_CMP1:
                begin
                    if (t1_reg < t2_reg)
                    begin
                        armed_reg <= 1'b0;
                        state_reg <= S_ADV;
                    end
                    else
                        state_reg <= S_M4;
                end
                S_M4:
                begin
                    t1_reg    <= mul_p;
                    state_reg <= S_M5;
                end
                S_M5, S_M6:
                begin
                    t2_reg    <= mul_p;
                    state_reg <= state_reg + 1'b1;
                end
                S_CMP2:
                begin
                    if (arm_skip)
                        state_reg <= S_ADV;
                    else
                    begin
                        armed_reg <= 1'b1;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sq_done)
                    begin
                        r_reg     <= sq_root;
                        len_reg   <= LW'(len_cfg_reg) << FRAC_BITS;
                        sel_reg   <= 1'b0;
                        state_reg <= S_AXIS;
                    end
                end
                // Fit the stroke inside the screen, one axis at a time
                S_AXIS:
                begin
                    if (s_cur == 0 || room <= 0)
                    begin
                        if (s_cur != 0)
                            len_reg <= '0;
                        sel_reg   <= 1'b1;
                        state_reg <= sel_reg ? S_LCHK : S_AXIS;
                    end
                    else
                        state_reg <= S_AMUL;
                end
                S_AMUL:
                begin
                    t1_reg    <= mul_p;
                    state_reg <= S_ADST;
                end
                S_ADST:
                    state_reg <= S_ADW;
                S_ADW:
                begin
                    if (div_done)
                    begin
                        if (div_quo < NW'(len_reg))
                            len_reg <= LW'(div_quo);
                        sel_reg   <= 1'b1;
                        state_reg <= sel_reg ? S_LCHK : S_AXIS;
                    end
                end
                S_LCHK:
                begin
                    sel_reg   <= 1'b0;
                    state_reg <= (len_reg < MINLEN) ? S_ADV : S_EMUL;
                end
                // End point along the flick direction
                S_EMUL:
                begin
                    t1_reg    <= mul_p;
                    state_reg <= S_EDST;
                end
                S_EDST:
                    state_reg <= S_EDW;
                S_EDW:
                begin
                    if (div_done)
                    begin
                        if (sel_reg)
                        begin
                            end_y_reg   <= end_new;
                            start_x_reg <= PTW'(cx_reg);
                            start_y_reg <= PTW'(cy_reg);
                            active_reg  <= 1'b1;
                            fidx_reg    <= '0;
                            ftot_reg    <= (frames_reg < sfsg_pkg::FRAMES_MIN) ?
                                           sfsg_pkg::FRAMES_MIN : frames_reg;
                            state_reg   <= S_ADV;
                        end
                        else
                        begin
                            end_x_reg <= end_new;
                            sel_reg   <= 1'b1;
                            state_reg <= S_EMUL;
                        end
                    end
                end
                // Advance the running stroke by one frame
                S_ADV:
                begin
                    if (!active_reg)
                        state_reg <= S_IDLE;
                    else if (fidx_reg == 8'd0)
                    begin
                        last_x_reg  <= start_x_reg;
                        last_y_reg  <= start_y_reg;
                        fidx_reg    <= 8'd1;
                        pk_reg      <= sfsg_pkg::EV_DOWN;
                        pprev_x_reg <= start_x_reg;
                        pprev_y_reg <= start_y_reg;
                        ppos_x_reg  <= start_x_reg;
                        ppos_y_reg  <= start_y_reg;
                        state_reg   <= S_EMIT;
                    end
                    else if (fidx_reg < ftot_reg)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= S_VMUL;
                    end
                    else
                    begin
                        active_reg  <= 1'b0;
                        pk_reg      <= sfsg_pkg::EV_UP;
                        pprev_x_reg <= end_x_reg;
                        pprev_y_reg <= end_y_reg;
                        ppos_x_reg  <= end_x_reg;
                        ppos_y_reg  <= end_y_reg;
                        state_reg   <= S_EMIT;
                    end
                end
                S_VMUL:
                begin
                    t1_reg    <= mul_p;
                    state_reg <= S_VDST;
                end
                S_VDST:
                    state_reg <= S_VDW;
                S_VDW:
                begin
                    if (div_done)
                    begin
                        if (sel_reg)
                        begin
                            new_y_reg <= mov_new;
                            state_reg <= S_VFIN;
                        end
                        else
                        begin
                            new_x_reg <= mov_new;
                            sel_reg   <= 1'b1;
                            state_reg <= S_VMUL;
                        end
                    end
                end
                S_VFIN:
                begin
                    last_x_reg  <= new_x_reg;
                    last_y_reg  <= new_y_reg;
                    fidx_reg    <= fidx_reg + 1'b1;
                    pk_reg      <= sfsg_pkg::EV_MOVE;
                    pprev_x_reg <= last_x_reg;
                    pprev_y_reg <= last_y_reg;
                    ppos_x_reg  <= new_x_reg;
                    ppos_y_reg  <= new_y_reg;
                    if (new_x_reg == last_x_reg && new_y_reg == last_y_reg)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_EMIT;
                end
                // Hold the event until the output register is free
                S_EMIT:
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && (!ov_reg || out_ready))
        begin
            ok_reg      <= pk_reg;
            oprev_x_reg <= FW'(pprev_x_reg & CMAX);
            oprev_y_reg <= FW'(pprev_y_reg & CMAX);
            opos_x_reg  <= FW'(ppos_x_reg & CMAX);
            opos_y_reg  <= FW'(ppos_y_reg & CMAX);
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign event_kind = ok_reg;
    assign prev_x     = oprev_x_reg;
    assign prev_y     = oprev_y_reg;
    assign pos_x      = opos_x_reg;
    assign pos_y      = opos_y_reg;

endmodule

[src/sfsg_checker.sv]
// Port-level checker for the stick flick swipe generator, with its bind.
// Depends on sfsg_pkg.
module sfsg_props (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [1:0]                   event_kind,
    input logic [sfsg_pkg::FIELD_W-1:0] prev_x,
    input logic [sfsg_pkg::FIELD_W-1:0] prev_y,
    input logic [sfsg_pkg::FIELD_W-1:0] pos_x,
    input logic [sfsg_pkg::FIELD_W-1:0] pos_y
);

    // A stalled request stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped while stalled");

    // Only the three event kinds leave the block
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == sfsg_pkg::EV_DOWN ||
                       event_kind == sfsg_pkg::EV_MOVE ||
                       event_kind == sfsg_pkg::EV_UP))
        else $error("unknown event kind");

    // Down and up carry one point
    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == sfsg_pkg::EV_DOWN || event_kind == sfsg_pkg::EV_UP)
        |-> (prev_x == pos_x && prev_y == pos_y))
        else $error("down or up with differing points");

    // Moves with no delta are suppressed
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == sfsg_pkg::EV_MOVE
        |-> (prev_x != pos_x || prev_y != pos_y))
        else $error("zero-delta move emitted");

endmodule

bind stick_flick_swipe_generator sfsg_props u_sfsg_props (.*);
